@@ rtl/multichannel_pwm_generator_defines.svh @@
// assertion macros for the multichannel pwm generator
// no dependencies; included by files that carry concurrent assertions
`ifndef MULTICHANNEL_PWM_GENERATOR_DEFINES_SVH
`define MULTICHANNEL_PWM_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
// immediate implication under reset
`define MPWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mpwm assertion failed");
// next-cycle implication under reset
`define MPWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mpwm assertion failed");
`else
`define MPWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MPWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/mpwm_pkg.sv @@
// shared types and constants of the multichannel pwm generator
// no dependencies
package mpwm_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int LEVEL_WIDTH = 6;
	localparam int MIN_PERIOD = 2;
	localparam int PRESCALE_STEP = 4;

	// control word field positions
	localparam int TRIG_POS = 0;
	localparam int POL_POS = 8;
	localparam int TYPE_POS = 16;
	localparam int SMOOTH_POS = 24;

	// register word indexes
	localparam logic [3:0] REG_CONTROL = 4'd0;
	localparam logic [3:0] REG_PRESCALE = 4'd1;
	localparam logic [3:0] REG_FIRST_CHAN = 4'd2;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_TICK  = 2'd2
	} action_t;

	// decoded access, one lane per possible channel
	typedef struct packed {
		logic                    tick;
		logic                    wr_ctrl;
		logic                    wr_prescale;
		logic [MAX_CHANNELS-1:0] wr_period;
		logic [MAX_CHANNELS-1:0] wr_duty;
		logic [MAX_CHANNELS-1:0] rise;
		logic                    rd_ctrl;
		logic                    rd_prescale;
		logic                    rd_period;
		logic                    rd_duty;
		logic [2:0]              chan;
		logic                    bad;
	} acc_t;

endpackage

@@ rtl/mpwm_in_if.sv @@
// command channel of the pwm generator: access or tick items
// no dependencies
interface mpwm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [3:0]  reg_index;
	logic [31:0] write_value;

	modport source (output valid, output action, output reg_index, output write_value,
		input ready);
	modport sink (input valid, input action, input reg_index, input write_value,
		output ready);
endinterface

@@ rtl/mpwm_out_if.sv @@
// result channel of the pwm generator: read data, levels, error flag
// no dependencies
interface mpwm_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_value;
	logic [5:0]  pwm_levels;
	logic        bad_index;

	modport source (output valid, output read_value, output pwm_levels, output bad_index,
		input ready);
	modport sink (input valid, input read_value, input pwm_levels, input bad_index,
		output ready);
endinterface

@@ rtl/mpwm_decode.sv @@
// access decoder: turns one registered item into per-channel strobes
// depends on mpwm_pkg
module mpwm_decode #(
	parameter int CHANNELS = 6
) (
	input  logic [1:0]          action,
	input  logic [3:0]          reg_index,
	input  logic [31:0]         write_value,
	input  logic [CHANNELS-1:0] trigger,
	output mpwm_pkg::acc_t      acc
);
	import mpwm_pkg::*;

	localparam logic [4:0] EndIdx = 5'(2 + 2 * CHANNELS);

	logic       is_rd;
	logic       is_wr;
	logic       chan_hit;
	logic [3:0] rel_idx;
	logic [CHANNELS-1:0] rise;

	assign rel_idx = reg_index - REG_FIRST_CHAN;
	assign chan_hit = (reg_index >= REG_FIRST_CHAN) && ({1'b0, reg_index} < EndIdx);
	assign rise = write_value[TRIG_POS +: CHANNELS] & ~trigger;

	always_comb begin
		is_rd = 1'b0;
		is_wr = 1'b0;
		acc = '0;
		case (action_t'(action))
			ACT_READ:  is_rd = 1'b1;
			ACT_WRITE: is_wr = 1'b1;
			ACT_TICK:  acc.tick = 1'b1;
			default:   acc.tick = 1'b0;
		endcase
		acc.chan = rel_idx[3:1];
		if (is_rd || is_wr) begin
			if (reg_index == REG_CONTROL) begin
				acc.rd_ctrl = is_rd;
				acc.wr_ctrl = is_wr;
				if (is_wr)
					acc.rise = MAX_CHANNELS'(rise);
			end else if (reg_index == REG_PRESCALE) begin
				acc.rd_prescale = is_rd;
				acc.wr_prescale = is_wr;
			end else if (chan_hit) begin
				if (!reg_index[0]) begin
					acc.rd_period = is_rd;
					if (is_wr)
						acc.wr_period = MAX_CHANNELS'(1) << rel_idx[3:1];
				end else begin
					acc.rd_duty = is_rd;
					if (is_wr)
						acc.wr_duty = MAX_CHANNELS'(1) << rel_idx[3:1];
				end
			end else begin
				acc.bad = 1'b1;
			end
		end
	end

endmodule

@@ rtl/mpwm_channel.sv @@
// one pwm channel: shadow and active sets, prescale divider, period counter
// depends on mpwm_pkg
module mpwm_channel #(
	parameter int CHAN = 0,
	parameter int COUNT_WIDTH = 24,
	parameter int PRESCALE_WIDTH = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  mpwm_pkg::acc_t            acc,
	input  logic [31:0]               write_value,
	input  logic                      pol_new,
	output logic [PRESCALE_WIDTH-1:0] prescale_shadow,
	output logic [COUNT_WIDTH-1:0]    period_shadow,
	output logic [COUNT_WIDTH-1:0]    duty_shadow,
	output logic                      level_d
);
	import mpwm_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] MinPeriod = COUNT_WIDTH'(MIN_PERIOD);

	logic [PRESCALE_WIDTH-1:0] pre_sh_q, pre_act_q, pre_act_d, div_q, div_d;
	logic [COUNT_WIDTH-1:0]    per_sh_q, duty_sh_q;
	logic [COUNT_WIDTH-1:0]    per_act_q, per_act_d, duty_act_q, duty_act_d, cnt_q, cnt_d;
	logic                      pol_act_q, pol_act_d;
	logic [COUNT_WIDTH:0]      cnt_inc;
	logic                      on;

	assign cnt_inc = {1'b0, cnt_q} + (COUNT_WIDTH + 1)'(1);

	always_comb begin
		pre_act_d = pre_act_q;
		per_act_d = per_act_q;
		duty_act_d = duty_act_q;
		pol_act_d = pol_act_q;
		cnt_d = cnt_q;
		div_d = div_q;
		if (acc.rise[CHAN]) begin
			pre_act_d = pre_sh_q;
			per_act_d = per_sh_q;
			duty_act_d = duty_sh_q;
			pol_act_d = pol_new;
			cnt_d = '0;
			div_d = '0;
		end else if (acc.tick) begin
			if (per_act_q < MinPeriod) begin
				cnt_d = '0;
				div_d = '0;
			end else if (div_q >= pre_act_q) begin
				div_d = '0;
				if (cnt_inc >= {1'b0, per_act_q})
					cnt_d = '0;
				else
					cnt_d = cnt_inc[COUNT_WIDTH-1:0];
			end else begin
				div_d = div_q + PRESCALE_WIDTH'(1);
			end
		end
	end

	assign on = (per_act_d >= MinPeriod) && (cnt_d < duty_act_d);
	assign level_d = on ? pol_act_d : ~pol_act_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_sh_q <= '0;
			per_sh_q <= '0;
			duty_sh_q <= '0;
			pre_act_q <= '0;
			per_act_q <= '0;
			duty_act_q <= '0;
			pol_act_q <= 1'b0;
			cnt_q <= '0;
			div_q <= '0;
		end else if (en) begin
			if (acc.wr_prescale)
				pre_sh_q <= write_value[PRESCALE_STEP * CHAN +: PRESCALE_WIDTH];
			if (acc.wr_period[CHAN])
				per_sh_q <= write_value[COUNT_WIDTH-1:0];
			if (acc.wr_duty[CHAN])
				duty_sh_q <= write_value[COUNT_WIDTH-1:0];
			pre_act_q <= pre_act_d;
			per_act_q <= per_act_d;
			duty_act_q <= duty_act_d;
			pol_act_q <= pol_act_d;
			cnt_q <= cnt_d;
			div_q <= div_d;
		end
	end

	assign prescale_shadow = pre_sh_q;
	assign period_shadow = per_sh_q;
	assign duty_shadow = duty_sh_q;

endmodule

@@ rtl/multichannel_pwm_generator.sv @@
// top level of the multichannel pwm generator: item registers, control word, readback
// depends on mpwm_pkg, mpwm_in_if, mpwm_out_if, mpwm_decode, mpwm_channel and the defines header
//
// Each command item is a register read, a register write or one prescaler clock tick.
// The block takes one item per clock cycle and keeps that rate while results are being
// taken; an item is captured in an input register, and when it moves on the whole state
// update (trigger edge load, divider and period counters of all channels, readback) is
// done in one step into the result register. The rate is set by that update of the
// per-channel counters. Period, duty and prescale writes land in shadow registers; a
// rising trigger bit in a control write copies a channel's shadow set and polarity into
// its active set and restarts its counters. pwm_levels reports each channel's level after
// the update; a period below two holds the idle level. There is no clearing pass: all
// control and channel state resets to zero at once, so every channel idles high
// after reset.
module multichannel_pwm_generator #(
	parameter int CHANNELS = 6,
	parameter int COUNT_WIDTH = 24,
	parameter int PRESCALE_WIDTH = 3
) (
	input logic clk,
	input logic arst_n,
	mpwm_in_if.sink cmd,
	mpwm_out_if.source rsp
);
	import mpwm_pkg::*;
	`include "multichannel_pwm_generator_defines.svh"

	// input register
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [3:0]  reg_index_s1;
	logic [31:0] write_value_s1;

	// result register
	logic        valid_s2;
	logic [31:0] read_value_s2;
	logic [LEVEL_WIDTH-1:0] pwm_levels_s2;
	logic        bad_index_s2;

	// control word bits
	logic [CHANNELS-1:0] trigger_q, polarity_q, type_q, smooth_q;

	logic adv;
	acc_t acc;
	logic [31:0] rd_value;
	logic [CHANNELS-1:0] level_d;
	logic [MAX_CHANNELS-1:0] level_pad;

	logic [PRESCALE_WIDTH-1:0] pre_sh [CHANNELS];
	logic [COUNT_WIDTH-1:0]    per_sh [CHANNELS];
	logic [COUNT_WIDTH-1:0]    duty_sh [CHANNELS];

	// the stage-one item moves on when the result register is free or being emptied
	assign adv = valid_s1 && (!valid_s2 || rsp.ready);
	assign cmd.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (cmd.ready)
			valid_s1 <= cmd.valid;
	end

	// item payload needs no reset
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			action_s1 <= cmd.action;
			reg_index_s1 <= cmd.reg_index;
			write_value_s1 <= cmd.write_value;
		end
	end

	mpwm_decode #(
		.CHANNELS(CHANNELS)
	) u_decode (
		.action(action_s1),
		.reg_index(reg_index_s1),
		.write_value(write_value_s1),
		.trigger(trigger_q),
		.acc(acc)
	);

	// control word holds trigger, polarity, type and smooth bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q <= '0;
			polarity_q <= '0;
			type_q <= '0;
			smooth_q <= '0;
		end else if (adv && acc.wr_ctrl) begin
			trigger_q <= write_value_s1[TRIG_POS +: CHANNELS];
			polarity_q <= write_value_s1[POL_POS +: CHANNELS];
			type_q <= write_value_s1[TYPE_POS +: CHANNELS];
			smooth_q <= write_value_s1[SMOOTH_POS +: CHANNELS];
		end
	end

	// one channel slice each
	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		mpwm_channel #(
			.CHAN(c),
			.COUNT_WIDTH(COUNT_WIDTH),
			.PRESCALE_WIDTH(PRESCALE_WIDTH)
		) u_chan (
			.clk(clk),
			.arst_n(arst_n),
			.en(adv),
			.acc(acc),
			.write_value(write_value_s1),
			.pol_new(write_value_s1[POL_POS + c]),
			.prescale_shadow(pre_sh[c]),
			.period_shadow(per_sh[c]),
			.duty_shadow(duty_sh[c]),
			.level_d(level_d[c])
		);
	end

	// readback: control word, packed prescale word, or one channel's shadow count
	always_comb begin
		rd_value = '0;
		if (acc.rd_ctrl) begin
			rd_value[TRIG_POS +: CHANNELS] = trigger_q;
			rd_value[POL_POS +: CHANNELS] = polarity_q;
			rd_value[TYPE_POS +: CHANNELS] = type_q;
			rd_value[SMOOTH_POS +: CHANNELS] = smooth_q;
		end else if (acc.rd_prescale) begin
			for (int c = 0; c < CHANNELS; c++)
				rd_value[PRESCALE_STEP * c +: PRESCALE_WIDTH] = pre_sh[c];
		end else if (acc.rd_period || acc.rd_duty) begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (acc.chan == 3'(c))
					rd_value = acc.rd_period ? 32'(per_sh[c]) : 32'(duty_sh[c]);
			end
		end
	end

	// only the low channels reach the level port
	assign level_pad = MAX_CHANNELS'(level_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= 1'b1;
		else if (rsp.ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_value_s2 <= rd_value;
			pwm_levels_s2 <= level_pad[LEVEL_WIDTH-1:0];
			bad_index_s2 <= acc.bad;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.read_value = read_value_s2;
	assign rsp.pwm_levels = pwm_levels_s2;
	assign rsp.bad_index = bad_index_s2;

	// input side stalls only when both stages are full and the result is held
	`MPWM_ASSERT_NOW(a_stall_cause, clk, arst_n, !cmd.ready, valid_s1 && valid_s2 && !rsp.ready)
	// a moved item always shows up as a result
	`MPWM_ASSERT_NEXT(a_adv_result, clk, arst_n, adv, valid_s2)
	// an access to no register reads as zero
	`MPWM_ASSERT_NOW(a_bad_zero, clk, arst_n, valid_s2 && bad_index_s2, read_value_s2 == 32'd0)
	// control writes land in the trigger bits
	`MPWM_ASSERT_NEXT(a_trig_write, clk, arst_n, adv && acc.wr_ctrl,
		trigger_q == $past(write_value_s1[TRIG_POS +: CHANNELS]))

endmodule
